@@ design/isotp_pkg.sv @@
package isotp_pkg;

  localparam int Q_DEPTH = 2;

  // one terminated string, as handed from the parser to the time unit
  typedef struct packed {
    logic        ok;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [9:0]  ms;
    logic        off_neg;
    logic [6:0]  off_hours;
    logic [6:0]  off_minutes;
  } rec_t;

  // days from March 1 to the first of month index mm (March = 0)
  function automatic logic [8:0] days_before_month(input logic [3:0] mm);
    logic [8:0] d;
    case (mm)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd61;
      4'd3:    d = 9'd92;
      4'd4:    d = 9'd122;
      4'd5:    d = 9'd153;
      4'd6:    d = 9'd184;
      4'd7:    d = 9'd214;
      4'd8:    d = 9'd245;
      4'd9:    d = 9'd275;
      4'd10:   d = 9'd306;
      4'd11:   d = 9'd337;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

@@ design/iso8601_timestamp_parser.sv @@
// ISO 8601 timestamp parser: characters in, Unix milliseconds out.
// Input queue port: in_char_code is taken when in_push is high and in_full
// is low, one character per cycle with no gaps needed. A zero byte closes
// the string and produces exactly one result transaction; all other
// characters produce none.
// Output queue port: while out_empty is low, out_unix_ms and out_valid_res
// hold the oldest result; it is taken when out_pop is high. out_valid_res
// is 0 (and out_unix_ms 0) for a malformed string or an instant at or
// before the epoch.
// Processing: the back unit takes each string from the buffer, counts the
// eras of the date (year / 400) by repeated subtraction, then forms the day
// count, the products and their sum before loading the output register.
// Throughput: one character per cycle; terminated strings queue in a
// QUEUE_DEPTH entry buffer between the parser and the time unit, and
// in_full rises only when that buffer is full, e.g. while the receiver
// leaves a result unpopped.
// Reset (rst_n low, synchronous) empties the buffer and the output
// register and puts the parser at the first year digit.
module iso8601_timestamp_parser
  import isotp_pkg::*;
#(
  parameter int QUEUE_DEPTH = Q_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  input  logic [7:0]  in_char_code,
  output logic        in_full,
  input  logic        out_pop,
  output logic        out_empty,
  output logic [47:0] out_unix_ms,
  output logic        out_valid_res
);

  logic q_full, q_empty, q_push, q_pop;
  rec_t q_wdata, q_rdata;

  isotp_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_char_code (in_char_code),
    .in_full      (in_full),
    .q_full       (q_full),
    .rec_push     (q_push),
    .rec_data     (q_wdata)
  );

  isotp_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  isotp_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .q_data        (q_rdata),
    .q_pop         (q_pop),
    .out_pop       (out_pop),
    .out_empty     (out_empty),
    .out_unix_ms   (out_unix_ms),
    .out_valid_res (out_valid_res)
  );

endmodule

@@ design/isotp_front.sv @@
module isotp_front
  import isotp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  input  logic [7:0] in_char_code,
  output logic       in_full,
  input  logic       q_full,
  output logic       rec_push,
  output rec_t       rec_data
);

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_T_UP  = 8'h54;
  localparam logic [7:0] CH_T_LO  = 8'h74;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_Z_UP  = 8'h5A;
  localparam logic [7:0] CH_Z_LO  = 8'h7A;

  typedef enum logic [4:0] {
    PH_YEAR, PH_DASH1, PH_MONTH, PH_DASH2, PH_DAY, PH_SEP, PH_HOUR, PH_COLON1,
    PH_MINUTE, PH_COLON2, PH_SECOND, PH_AFTER_SEC, PH_FRAC1, PH_FRAC,
    PH_OFF_HOUR, PH_OFF_MID, PH_OFF_MIN, PH_END
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [13:0] year_r, year_nxt;
  logic [6:0]  month_r, month_nxt;
  logic [6:0]  day_r, day_nxt;
  logic [6:0]  hour_r, hour_nxt;
  logic [6:0]  minute_r, minute_nxt;
  logic [6:0]  second_r, second_nxt;
  logic [9:0]  milli_r, milli_nxt;
  logic [1:0]  frac_r, frac_nxt;
  logic        neg_r, neg_nxt;
  logic [6:0]  offh_r, offh_nxt;
  logic [6:0]  offm_r, offm_nxt;
  logic        failed_r, failed_nxt;

  logic       accept, term, is_dig, is_z, is_sign;
  logic [3:0] dig;
  logic       phase_ok, range_ok;
  logic [9:0] ms_pad;

  function automatic logic [6:0] acc2(input logic [6:0] a, input logic [3:0] d);
    return 7'(a * 7'd10 + 7'(d));
  endfunction

  assign in_full  = q_full;
  assign accept   = in_push && !q_full;
  assign term     = (in_char_code == CH_NUL);
  assign rec_push = accept && term;
  assign is_dig   = (in_char_code >= CH_ZERO) && (in_char_code <= CH_NINE);
  assign dig      = in_char_code[3:0];
  assign is_z     = (in_char_code == CH_Z_UP) || (in_char_code == CH_Z_LO);
  assign is_sign  = (in_char_code == CH_PLUS) || (in_char_code == CH_DASH);

  assign phase_ok = (phase_r == PH_AFTER_SEC) || (phase_r == PH_FRAC) || (phase_r == PH_END);
  assign range_ok = (month_r >= 7'd1) && (month_r <= 7'd12) && (day_r >= 7'd1) &&
                    (day_r <= 7'd31) && (hour_r <= 7'd23) && (minute_r <= 7'd59) &&
                    (second_r <= 7'd60);

  always_comb begin
    case (frac_r)
      2'd0:    ms_pad = '0;
      2'd1:    ms_pad = 10'(milli_r * 10'd100);
      2'd2:    ms_pad = 10'(milli_r * 10'd10);
      default: ms_pad = milli_r;
    endcase
  end

  always_comb begin
    rec_data.ok          = !failed_r && phase_ok && range_ok;
    rec_data.year        = year_r;
    rec_data.month       = month_r[3:0];
    rec_data.day         = day_r[4:0];
    rec_data.hour        = hour_r[4:0];
    rec_data.minute      = minute_r[5:0];
    rec_data.second      = second_r[5:0];
    rec_data.ms          = ms_pad;
    rec_data.off_neg     = neg_r;
    rec_data.off_hours   = offh_r;
    rec_data.off_minutes = offm_r;
  end

  always_comb begin
    phase_nxt  = phase_r;
    cnt_nxt    = cnt_r;
    year_nxt   = year_r;
    month_nxt  = month_r;
    day_nxt    = day_r;
    hour_nxt   = hour_r;
    minute_nxt = minute_r;
    second_nxt = second_r;
    milli_nxt  = milli_r;
    frac_nxt   = frac_r;
    neg_nxt    = neg_r;
    offh_nxt   = offh_r;
    offm_nxt   = offm_r;
    failed_nxt = failed_r;
    if (accept) begin
      if (term) begin
        phase_nxt  = PH_YEAR;
        cnt_nxt    = '0;
        year_nxt   = '0;
        month_nxt  = '0;
        day_nxt    = '0;
        hour_nxt   = '0;
        minute_nxt = '0;
        second_nxt = '0;
        milli_nxt  = '0;
        frac_nxt   = '0;
        neg_nxt    = 1'b0;
        offh_nxt   = '0;
        offm_nxt   = '0;
        failed_nxt = 1'b0;
      end else if (!failed_r) begin
        unique case (phase_r) inside
          PH_YEAR: begin
            if (is_dig) begin
              year_nxt = 14'(year_r * 14'd10 + 14'(dig));
              cnt_nxt  = cnt_r + 3'd1;
              if (cnt_r == 3'd3) begin
                cnt_nxt   = '0;
                phase_nxt = PH_DASH1;
              end
            end else failed_nxt = 1'b1;
          end
          PH_DASH1: begin
            if (in_char_code == CH_DASH) phase_nxt = PH_MONTH;
            else failed_nxt = 1'b1;
          end
          PH_MONTH: begin
            if (is_dig) begin
              month_nxt = acc2(month_r, dig);
              cnt_nxt   = cnt_r + 3'd1;
              if (cnt_r == 3'd1) begin
                cnt_nxt   = '0;
                phase_nxt = PH_DASH2;
              end
            end else failed_nxt = 1'b1;
          end
          PH_DASH2: begin
            if (in_char_code == CH_DASH) phase_nxt = PH_DAY;
            else failed_nxt = 1'b1;
          end
          PH_DAY: begin
            if (is_dig) begin
              day_nxt = acc2(day_r, dig);
              cnt_nxt = cnt_r + 3'd1;
              if (cnt_r == 3'd1) begin
                cnt_nxt   = '0;
                phase_nxt = PH_SEP;
              end
            end else failed_nxt = 1'b1;
          end
          PH_SEP: begin
            if ((in_char_code == CH_T_UP) || (in_char_code == CH_T_LO) ||
                (in_char_code == CH_SPACE)) phase_nxt = PH_HOUR;
            else failed_nxt = 1'b1;
          end
          PH_HOUR: begin
            if (is_dig) begin
              hour_nxt = acc2(hour_r, dig);
              cnt_nxt  = cnt_r + 3'd1;
              if (cnt_r == 3'd1) begin
                cnt_nxt   = '0;
                phase_nxt = PH_COLON1;
              end
            end else failed_nxt = 1'b1;
          end
          PH_COLON1: begin
            if (in_char_code == CH_COLON) phase_nxt = PH_MINUTE;
            else failed_nxt = 1'b1;
          end
          PH_MINUTE: begin
            if (is_dig) begin
              minute_nxt = acc2(minute_r, dig);
              cnt_nxt    = cnt_r + 3'd1;
              if (cnt_r == 3'd1) begin
                cnt_nxt   = '0;
                phase_nxt = PH_COLON2;
              end
            end else failed_nxt = 1'b1;
          end
          PH_COLON2: begin
            if (in_char_code == CH_COLON) phase_nxt = PH_SECOND;
            else failed_nxt = 1'b1;
          end
          PH_SECOND: begin
            if (is_dig) begin
              second_nxt = acc2(second_r, dig);
              cnt_nxt    = cnt_r + 3'd1;
              if (cnt_r == 3'd1) begin
                cnt_nxt   = '0;
                phase_nxt = PH_AFTER_SEC;
              end
            end else failed_nxt = 1'b1;
          end
          PH_AFTER_SEC: begin
            if ((in_char_code == CH_DOT) || (in_char_code == CH_COMMA)) begin
              phase_nxt = PH_FRAC1;
            end else if (is_z) begin
              phase_nxt = PH_END;
            end else if (is_sign) begin
              neg_nxt   = (in_char_code == CH_DASH);
              cnt_nxt   = '0;
              phase_nxt = PH_OFF_HOUR;
            end else failed_nxt = 1'b1;
          end
          PH_FRAC1, PH_FRAC: begin
            if (is_dig) begin
              if (frac_r != 2'd3) begin
                milli_nxt = 10'(milli_r * 10'd10 + 10'(dig));
                frac_nxt  = frac_r + 2'd1;
              end
              phase_nxt = PH_FRAC;
            end else if (phase_r == PH_FRAC1) begin
              failed_nxt = 1'b1;
            end else if (is_z) begin
              phase_nxt = PH_END;
            end else if (is_sign) begin
              neg_nxt   = (in_char_code == CH_DASH);
              cnt_nxt   = '0;
              phase_nxt = PH_OFF_HOUR;
            end else failed_nxt = 1'b1;
          end
          PH_OFF_HOUR: begin
            if (is_dig) begin
              offh_nxt = acc2(offh_r, dig);
              cnt_nxt  = cnt_r + 3'd1;
              if (cnt_r == 3'd1) begin
                cnt_nxt   = '0;
                phase_nxt = PH_OFF_MID;
              end
            end else failed_nxt = 1'b1;
          end
          PH_OFF_MID: begin
            if (in_char_code == CH_COLON) begin
              cnt_nxt   = '0;
              phase_nxt = PH_OFF_MIN;
            end else if (is_dig) begin
              offm_nxt  = 7'(dig);
              cnt_nxt   = 3'd1;
              phase_nxt = PH_OFF_MIN;
            end else failed_nxt = 1'b1;
          end
          PH_OFF_MIN: begin
            if (is_dig) begin
              offm_nxt = acc2(offm_r, dig);
              cnt_nxt  = cnt_r + 3'd1;
              if (cnt_r == 3'd1) begin
                cnt_nxt   = '0;
                phase_nxt = PH_END;
              end
            end else failed_nxt = 1'b1;
          end
          default: failed_nxt = 1'b1;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_YEAR;
      cnt_r    <= '0;
      year_r   <= '0;
      month_r  <= '0;
      day_r    <= '0;
      hour_r   <= '0;
      minute_r <= '0;
      second_r <= '0;
      milli_r  <= '0;
      frac_r   <= '0;
      neg_r    <= 1'b0;
      offh_r   <= '0;
      offm_r   <= '0;
      failed_r <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      cnt_r    <= cnt_nxt;
      year_r   <= year_nxt;
      month_r  <= month_nxt;
      day_r    <= day_nxt;
      hour_r   <= hour_nxt;
      minute_r <= minute_nxt;
      second_r <= second_nxt;
      milli_r  <= milli_nxt;
      frac_r   <= frac_nxt;
      neg_r    <= neg_nxt;
      offh_r   <= offh_nxt;
      offm_r   <= offm_nxt;
      failed_r <= failed_nxt;
    end
  end

endmodule

@@ design/isotp_fifo.sv @@
module isotp_fifo
  import isotp_pkg::*;
#(
  parameter int DEPTH = Q_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  rec_t wdata,
  output logic full,
  input  logic pop,
  output rec_t rdata,
  output logic empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  rec_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : PW'(p + 1'b1);
  endfunction

  assign full  = (cnt_r == CW'(DEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (pop) rd_ptr_r <= ptr_inc(rd_ptr_r);
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
    else $error("push while queue full");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n) !(pop && empty))
    else $error("pop while queue empty");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r <= CW'(DEPTH)) && ((cnt_r == '0) || (cnt_r == CW'(DEPTH)) || (wr_ptr_r != rd_ptr_r)))
    else $error("queue count inconsistent");
`endif

endmodule

@@ design/isotp_back.sv @@
module isotp_back
  import isotp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_empty,
  input  rec_t        q_data,
  output logic        q_pop,
  input  logic        out_pop,
  output logic        out_empty,
  output logic [47:0] out_unix_ms,
  output logic        out_valid_res
);

  localparam logic        [13:0] ERA_YEARS  = 14'd400;
  localparam logic signed [23:0] ERA_DAYS   = 24'sd146097;
  localparam logic signed [23:0] EPOCH_DAYS = 24'sd719468;
  localparam logic signed [49:0] DAY_MS     = 50'sd86400000;
  localparam logic signed [29:0] SEC_MS     = 30'sd1000;

  typedef enum logic [2:0] {
    B_IDLE, B_DIV, B_DOE, B_DAYS, B_MUL, B_SUM, B_OUT
  } bstate_t;

  bstate_t            state_r;
  rec_t               rec_r;
  logic        [13:0] rem_r;
  logic signed [5:0]  era_r;
  logic        [3:0]  mm_r;
  logic        [17:0] doe_r;
  logic        [18:0] off_r;
  logic        [16:0] hms_r;
  logic signed [23:0] days_r;
  logic signed [19:0] tod_r;
  logic signed [49:0] dms_r;
  logic signed [29:0] tms_r;
  logic signed [49:0] sum_r;
  logic               ovalid_r;
  logic        [47:0] oms_r;
  logic               ovres_r;

  logic               early, before_zero, pos;
  logic        [1:0]  c100;
  logic        [17:0] doe_nxt;
  logic signed [23:0] days_nxt;
  logic signed [19:0] tod_nxt;
  logic signed [29:0] tod_ext;

  assign q_pop       = (state_r == B_IDLE) && !q_empty;
  assign early       = (q_data.month <= 4'd2);
  assign before_zero = early && (q_data.year == '0);
  assign pos         = !sum_r[49] && (sum_r != '0);

  assign c100 = (rem_r >= 14'd300) ? 2'd3 : (rem_r >= 14'd200) ? 2'd2 :
                (rem_r >= 14'd100) ? 2'd1 : 2'd0;
  assign doe_nxt = 18'(rem_r) * 18'd365 + 18'(rem_r[13:2]) - 18'(c100) +
                   18'(days_before_month(mm_r)) + 18'(rec_r.day) - 18'd1;
  assign days_nxt = era_r * ERA_DAYS + $signed({6'b0, doe_r}) - EPOCH_DAYS;
  assign tod_nxt  = rec_r.off_neg ? ($signed({3'b0, hms_r}) + $signed({1'b0, off_r}))
                                  : ($signed({3'b0, hms_r}) - $signed({1'b0, off_r}));
  assign tod_ext  = 30'(tod_r);

  assign out_empty     = !ovalid_r;
  assign out_unix_ms   = oms_r;
  assign out_valid_res = ovres_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= B_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      if (out_pop && ovalid_r && (state_r != B_OUT)) ovalid_r <= 1'b0;
      unique case (state_r)
        B_IDLE: begin
          if (!q_empty) begin
            rec_r <= q_data;
            mm_r  <= early ? 4'(q_data.month + 4'd9) : 4'(q_data.month - 4'd3);
            if (before_zero) begin
              era_r   <= -6'sd1;
              rem_r   <= 14'd399;
              state_r <= B_DOE;
            end else begin
              era_r   <= '0;
              rem_r   <= q_data.year - 14'(early);
              state_r <= B_DIV;
            end
          end
        end
        B_DIV: begin
          if (rem_r >= ERA_YEARS) begin
            rem_r <= rem_r - ERA_YEARS;
            era_r <= era_r + 6'sd1;
          end else state_r <= B_DOE;
        end
        B_DOE: begin
          doe_r   <= doe_nxt;
          off_r   <= 19'(rec_r.off_hours) * 19'd3600 + 19'(rec_r.off_minutes) * 19'd60;
          hms_r   <= 17'(rec_r.hour) * 17'd3600 + 17'(rec_r.minute) * 17'd60 +
                     17'(rec_r.second);
          state_r <= B_DAYS;
        end
        B_DAYS: begin
          days_r  <= days_nxt;
          tod_r   <= tod_nxt;
          state_r <= B_MUL;
        end
        B_MUL: begin
          dms_r   <= days_r * DAY_MS;
          tms_r   <= tod_ext * SEC_MS + $signed({20'b0, rec_r.ms});
          state_r <= B_SUM;
        end
        B_SUM: begin
          sum_r   <= dms_r + 50'(tms_r);
          state_r <= B_OUT;
        end
        B_OUT: begin
          if (!ovalid_r || out_pop) begin
            ovalid_r <= 1'b1;
            ovres_r  <= rec_r.ok && pos;
            oms_r    <= (rec_r.ok && pos) ? sum_r[47:0] : '0;
            state_r  <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_valid_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (ovalid_r && ovres_r) |-> (oms_r != '0))
    else $error("valid result with zero time");
  a_era_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_DIV) |-> ((era_r >= 6'sd0) && (era_r <= 6'sd24)))
    else $error("era count out of range");
  a_pop_starts: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (state_r != B_IDLE))
    else $error("queue pop without starting a transaction");
`endif

endmodule
